// ===== hdl/cta_pkg.sv =====
package cta_pkg;

  localparam int YearWidth   = 14;
  localparam int MonthWidth  = 4;
  localparam int DayWidth    = 5;
  localparam int HourWidth   = 5;
  localparam int MinuteWidth = 6;
  localparam int SecondWidth = 6;
  localparam int MsecWidth   = 10;
  localparam int DeltaWidth  = 16;
  localparam int WorkWidth   = 17;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  localparam logic [DayWidth-1:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  localparam logic [DayWidth-1:0] LEAP_FEB_LEN = 5'd29;
  localparam logic [DayWidth-1:0] ODD_MONTH_LEN = 5'd31;

  function automatic logic [DayWidth-1:0] days_in(input logic [MonthWidth-1:0] m,
                                                  input logic leap);
    logic [DayWidth-1:0] len;
    if (m < 4'd1 || m > 4'd12) begin
      len = ODD_MONTH_LEN;
    end else if (m == 4'd2 && leap) begin
      len = LEAP_FEB_LEN;
    end else begin
      len = MONTH_LEN[m - 4'd1];
    end
    return len;
  endfunction

endpackage

// ===== hdl/calendar_time_advance.sv =====
// Channel  Direction  Handshake             Fields
// in       input      in_valid / in_ready   operation, load_*, delta_seconds, delta_milliseconds
// out      output     out_valid / out_ready year, month, day, hour, minute, second, millisecond
//
// The input is busy from acceptance until the word leaves the emit step. A load word is
// taken into the current time, then registered at the output from the emit step. An advance
// word adds its milliseconds and seconds on acceptance, then carries whole minutes in the step
// state, once per cycle through a single subtract-by-sixty and carry chain.
// Synchronous active-high reset sets the clock to 2004-06-05 14:00:00.000.
// A stalled output holds its word while the next word is computed; that word then waits in
// the emit step, and the input stays busy, until the output word is moved.
module calendar_time_advance
  import cta_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   operation,
  input  logic [YearWidth-1:0]   load_year,
  input  logic [MonthWidth-1:0]  load_month,
  input  logic [DayWidth-1:0]    load_day,
  input  logic [HourWidth-1:0]   load_hour,
  input  logic [MinuteWidth-1:0] load_minute,
  input  logic [SecondWidth-1:0] load_second,
  input  logic [MsecWidth-1:0]   load_millisecond,
  input  logic [DeltaWidth-1:0]  delta_seconds,
  input  logic [MsecWidth-1:0]   delta_milliseconds,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [YearWidth-1:0]   year,
  output logic [MonthWidth-1:0]  month,
  output logic [DayWidth-1:0]    day,
  output logic [HourWidth-1:0]   hour,
  output logic [MinuteWidth-1:0] minute,
  output logic [SecondWidth-1:0] second,
  output logic [MsecWidth-1:0]   millisecond
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_STEP = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]             state, state_next;
  logic [YearWidth-1:0]   cur_year, cur_year_next;
  logic [MonthWidth-1:0]  cur_month, cur_month_next;
  logic [DayWidth-1:0]    cur_day, cur_day_next;
  logic [HourWidth-1:0]   cur_hour, cur_hour_next;
  logic [MinuteWidth-1:0] cur_minute, cur_minute_next;
  logic [SecondWidth-1:0] cur_second, cur_second_next;
  logic [MsecWidth-1:0]   cur_msec, cur_msec_next;
  logic [WorkWidth-1:0]   work_sec, work_sec_next;
  logic                   leap, leap_next;
  logic                   out_valid_next;
  logic                   load_out;

  logic [MsecWidth:0]     ms_sum;
  logic                   ms_carry;
  logic [MinuteWidth:0]   min_inc;
  logic [HourWidth:0]     hour_inc;
  logic [DayWidth:0]      day_inc;
  logic [MonthWidth:0]    mon_inc;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next      = state;
    cur_year_next   = cur_year;
    cur_month_next  = cur_month;
    cur_day_next    = cur_day;
    cur_hour_next   = cur_hour;
    cur_minute_next = cur_minute;
    cur_second_next = cur_second;
    cur_msec_next   = cur_msec;
    work_sec_next   = work_sec;
    leap_next       = leap;
    out_valid_next  = out_valid && !out_ready;
    load_out        = 1'b0;

    ms_sum   = {1'b0, cur_msec} + {1'b0, delta_milliseconds};
    ms_carry = (ms_sum > 11'd999);
    min_inc  = {1'b0, cur_minute} + 7'd1;
    hour_inc = {1'b0, cur_hour} + 6'd1;
    day_inc  = {1'b0, cur_day} + 6'd1;
    mon_inc  = {1'b0, cur_month} + 5'd1;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (operation == OP_LOAD) begin
            cur_year_next   = load_year;
            cur_month_next  = load_month;
            cur_day_next    = load_day;
            cur_hour_next   = load_hour;
            cur_minute_next = load_minute;
            cur_second_next = load_second;
            cur_msec_next   = load_millisecond;
            state_next      = S_EMIT;
          end else begin
            leap_next = (cur_year[1:0] == 2'b00);
            if (ms_carry) begin
              cur_msec_next = ms_sum[MsecWidth-1:0] - 10'd1000;
            end else begin
              cur_msec_next = ms_sum[MsecWidth-1:0];
            end
            work_sec_next = WorkWidth'(cur_second) + WorkWidth'(ms_carry)
                          + WorkWidth'(delta_seconds);
            state_next    = S_STEP;
          end
        end
      end
      S_STEP: begin
        if (work_sec >= 17'd60) begin
          work_sec_next = work_sec - 17'd60;
          if (min_inc >= 7'd60) begin
            cur_minute_next = '0;
            if (hour_inc >= 6'd24) begin
              cur_hour_next = '0;
              if (day_inc > {1'b0, days_in(cur_month, leap)}) begin
                cur_day_next = 5'd1;
                if (mon_inc > 5'd12) begin
                  cur_month_next = 4'd1;
                  cur_year_next  = cur_year + 14'd1;
                end else begin
                  cur_month_next = mon_inc[MonthWidth-1:0];
                end
              end else begin
                cur_day_next = day_inc[DayWidth-1:0];
              end
            end else begin
              cur_hour_next = hour_inc[HourWidth-1:0];
            end
          end else begin
            cur_minute_next = min_inc[MinuteWidth-1:0];
          end
        end else begin
          cur_second_next = work_sec[SecondWidth-1:0];
          state_next      = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid || out_ready) begin
          load_out       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      cur_year   <= 14'd2004;
      cur_month  <= 4'd6;
      cur_day    <= 5'd5;
      cur_hour   <= 5'd14;
      cur_minute <= '0;
      cur_second <= '0;
      cur_msec   <= '0;
      leap       <= 1'b0;
    end else begin
      state      <= state_next;
      out_valid  <= out_valid_next;
      cur_year   <= cur_year_next;
      cur_month  <= cur_month_next;
      cur_day    <= cur_day_next;
      cur_hour   <= cur_hour_next;
      cur_minute <= cur_minute_next;
      cur_second <= cur_second_next;
      cur_msec   <= cur_msec_next;
      leap       <= leap_next;
    end
  end

  always_ff @(posedge clk) begin
    work_sec <= work_sec_next;
    if (load_out) begin
      year        <= cur_year;
      month       <= cur_month;
      day         <= cur_day;
      hour        <= cur_hour;
      minute      <= cur_minute;
      second      <= cur_second;
      millisecond <= cur_msec;
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken twice without a busy cycle");

  a_step_finish: assert property (@(posedge clk) disable iff (rst)
    (state == S_STEP && work_sec < 17'd60) |=> (state == S_EMIT && cur_second < 6'd60))
    else $error("carry loop did not finish with a second below sixty");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_EMIT)
    else $error("result word appeared without an emit cycle");

endmodule
